/* sv/sap1_pkg.sv */
// Shared types, codes and the microcode store for the 8-bit accumulator CPU step block.
// No dependencies; used by sap1_instruction_step and sap1_checker.
package sap1_pkg;

  localparam int unsigned IN_W    = 16;  // op, address, data packed, padded to bytes
  localparam int unsigned OUT_W   = 24;  // six result fields packed, padded to bytes
  localparam int unsigned UADDR_W = 5;   // microcode address width

  // Item operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_EXEC    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Instruction opcodes (high nibble of an instruction byte)
  localparam logic [3:0] OPC_NOP = 4'd0;
  localparam logic [3:0] OPC_LDA = 4'd1;
  localparam logic [3:0] OPC_ADD = 4'd2;
  localparam logic [3:0] OPC_SUB = 4'd3;
  localparam logic [3:0] OPC_STA = 4'd4;
  localparam logic [3:0] OPC_LDI = 4'd5;
  localparam logic [3:0] OPC_JMP = 4'd6;
  localparam logic [3:0] OPC_JC  = 4'd7;
  localparam logic [3:0] OPC_JZ  = 4'd8;
  localparam logic [3:0] OPC_INC = 4'd9;
  localparam logic [3:0] OPC_DEC = 4'd10;
  localparam logic [3:0] OPC_CMP = 4'd11;
  localparam logic [3:0] OPC_OUT = 4'd14;
  localparam logic [3:0] OPC_HLT = 4'd15;

  // Microcode addresses; per-opcode routines sit at {1, opcode}
  localparam logic [UADDR_W-1:0] U_IDLE    = 5'd0;
  localparam logic [UADDR_W-1:0] U_WRITE   = 5'd1;
  localparam logic [UADDR_W-1:0] U_EXEC    = 5'd2;
  localparam logic [UADDR_W-1:0] U_FETCH   = 5'd3;
  localparam logic [UADDR_W-1:0] U_RESTART = 5'd4;
  localparam logic [UADDR_W-1:0] U_DONE    = 5'd5;

  typedef enum logic [2:0] {
    SEQ_IDLE,   // wait for an input transaction, then dispatch on its op
    SEQ_GOTO,   // jump to target
    SEQ_HALT,   // jump to target when halted, else fall through
    SEQ_OPC,    // dispatch on the opcode just fetched
    SEQ_DONE    // load the result register when free, then go idle
  } seq_t;

  typedef enum logic [1:0] {RD_PC, RD_FETCHED} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_ITEM, WR_ACC} wr_sel_t;
  typedef enum logic [2:0] {PC_KEEP, PC_INC, PC_JMP, PC_JC, PC_JZ, PC_BACK} pc_op_t;
  typedef enum logic [1:0] {ALU_NONE, ALU_ADD, ALU_SUB} alu_t;
  typedef enum logic {B_MEM, B_NIB} bsel_t;
  typedef enum logic [1:0] {ACC_KEEP, ACC_ALU, ACC_MEM, ACC_NIB} acc_sel_t;

  typedef struct packed {
    seq_t               seq;
    rd_sel_t            rd;
    wr_sel_t            wr;
    logic               ir_ld;
    pc_op_t             pc;
    alu_t               alu;
    bsel_t              bsel;
    acc_sel_t           acc;
    logic               flags_ld;
    logic               oreg_ld;
    logic               halt_set;
    logic               clr;
    logic [UADDR_W-1:0] target;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = '{
    seq: SEQ_IDLE, rd: RD_PC, wr: WR_NONE, ir_ld: 1'b0, pc: PC_KEEP, alu: ALU_NONE,
    bsel: B_MEM, acc: ACC_KEEP, flags_ld: 1'b0, oreg_ld: 1'b0, halt_set: 1'b0,
    clr: 1'b0, target: U_IDLE
  };

  // Entry point of the routine for each item operation
  function automatic logic [UADDR_W-1:0] op_entry(input logic [1:0] op);
    logic [UADDR_W-1:0] e;
    unique case (op)
      OP_WRITE:   e = U_WRITE;
      OP_EXEC:    e = U_EXEC;
      OP_RESTART: e = U_RESTART;
      default:    e = U_DONE;
    endcase
    return e;
  endfunction

  // Microcode store: one control word per step
  function automatic ctrl_t ucode_rom(input logic [UADDR_W-1:0] ua);
    ctrl_t c;
    c = CTRL_IDLE;
    if (ua[UADDR_W-1]) begin
      // opcode routines: one step each, then report
      c.seq    = SEQ_GOTO;
      c.target = U_DONE;
      unique case (ua[3:0])
        OPC_LDA: c.acc = ACC_MEM;
        OPC_ADD: begin
          c.alu = ALU_ADD; c.acc = ACC_ALU; c.flags_ld = 1'b1;
        end
        OPC_SUB: begin
          c.alu = ALU_SUB; c.acc = ACC_ALU; c.flags_ld = 1'b1;
        end
        OPC_STA: c.wr = WR_ACC;
        OPC_LDI: c.acc = ACC_NIB;
        OPC_JMP: c.pc = PC_JMP;
        OPC_JC:  c.pc = PC_JC;
        OPC_JZ:  c.pc = PC_JZ;
        OPC_INC: begin
          c.alu = ALU_ADD; c.bsel = B_NIB; c.acc = ACC_ALU; c.flags_ld = 1'b1;
        end
        OPC_DEC: begin
          c.alu = ALU_SUB; c.bsel = B_NIB; c.acc = ACC_ALU; c.flags_ld = 1'b1;
        end
        OPC_CMP: begin
          c.alu = ALU_SUB; c.flags_ld = 1'b1;
        end
        OPC_OUT: c.oreg_ld = 1'b1;
        OPC_HLT: begin
          c.pc = PC_BACK; c.halt_set = 1'b1;
        end
        default: ;  // NOP and the unused opcodes
      endcase
    end else begin
      unique case (ua)
        U_IDLE: c.seq = SEQ_IDLE;
        U_WRITE: begin
          c.seq = SEQ_GOTO; c.wr = WR_ITEM; c.target = U_DONE;
        end
        U_EXEC: begin
          c.seq = SEQ_HALT; c.rd = RD_PC; c.target = U_DONE;
        end
        U_FETCH: begin
          c.seq = SEQ_OPC; c.ir_ld = 1'b1; c.pc = PC_INC; c.rd = RD_FETCHED;
        end
        U_RESTART: begin
          c.seq = SEQ_GOTO; c.clr = 1'b1; c.target = U_DONE;
        end
        U_DONE: c.seq = SEQ_DONE;
        default: begin
          c.seq = SEQ_GOTO; c.target = U_IDLE;
        end
      endcase
    end
    return c;
  endfunction

endpackage

/* sv/sap1_instruction_step.sv */
// Top level of the 8-bit accumulator CPU step block: microcode sequencer, datapath, memory.
// Depends on sap1_pkg for control word types, codes and the microcode store.
//
// One input transaction either writes a byte into the 16-byte program memory, executes one
// instruction, or restarts the CPU (registers and flags cleared, memory kept); each produces
// exactly one result transaction with the accumulator, output register, program counter and
// the carry, zero and halted flags. A microcode sequencer steps through a small control store.
// An instruction runs the steps idle/accept, halt check and fetch issue, instruction latch and
// operand read, execute, report; fetch and operand read are separate steps since the single read
// port of the program memory serves them in turn. A memory write or restart runs idle, its own
// step and report; an execute while halted goes from halt check to report, an unknown op from
// idle to report. The next input is accepted as soon as the sequencer is back in its idle step,
// even while the previous result still waits in the output register.
module sap1_instruction_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [sap1_pkg::IN_W-1:0] in_tdata,   // op[1:0], address[5:2], data[13:6], zero pad
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [sap1_pkg::OUT_W-1:0] out_tdata  // accumulator[7:0], output_value[15:8],
                                                // program_counter[19:16], carry[20],
                                                // zero[21], halted[22], zero pad
);
  import sap1_pkg::*;

  // sequencer
  logic [UADDR_W-1:0] upc_r, upc_nxt;
  ctrl_t              cw;

  // captured item payload
  logic [3:0] item_addr_r;
  logic [7:0] item_data_r;

  // program memory and its registered read port
  logic [7:0] mem [16];
  logic [7:0] rdata_r;
  logic [3:0] rd_addr;
  logic       mem_we;
  logic [3:0] wr_addr;
  logic [7:0] wr_data;

  // architectural state
  logic [7:0] ir_r;
  logic [7:0] acc_r, acc_nxt;
  logic [7:0] oreg_r, oreg_nxt;
  logic [3:0] pc_r, pc_nxt;
  logic       c_r, c_nxt;
  logic       z_r, z_nxt;
  logic       halt_r, halt_nxt;

  // ALU
  logic [7:0] alu_b;
  logic [8:0] sum9;
  logic [8:0] dif9;
  logic [7:0] alu_res;
  logic       alu_c;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r;
  logic                 out_free;
  logic                 out_ld;
  logic                 in_acc;

  assign cw        = ucode_rom(upc_r);
  assign in_tready = (cw.seq == SEQ_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign out_ld    = (cw.seq == SEQ_DONE) && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next microcode address
  always_comb begin
    unique case (cw.seq)
      SEQ_IDLE: upc_nxt = in_acc ? op_entry(in_tdata[1:0]) : upc_r;
      SEQ_GOTO: upc_nxt = cw.target;
      SEQ_HALT: upc_nxt = halt_r ? cw.target : upc_r + UADDR_W'(1);
      SEQ_OPC:  upc_nxt = {1'b1, rdata_r[7:4]};      // dispatch on the fetched opcode
      SEQ_DONE: upc_nxt = out_free ? U_IDLE : upc_r; // hold until the result slot frees
      default:  upc_nxt = U_IDLE;
    endcase
  end

  // Memory port selection: fetch at PC, operand at the low nibble of the fetched byte
  always_comb begin
    unique case (cw.rd)
      RD_FETCHED: rd_addr = rdata_r[3:0];
      default:    rd_addr = pc_r;
    endcase
    mem_we = (cw.wr != WR_NONE);
    if (cw.wr == WR_ITEM) begin
      wr_addr = item_addr_r;
      wr_data = item_data_r;
    end else begin
      wr_addr = ir_r[3:0];
      wr_data = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // ALU: 9-bit add and subtract; subtract carry means no borrow
  always_comb begin
    alu_b = (cw.bsel == B_MEM) ? rdata_r : {4'b0000, ir_r[3:0]};
    sum9  = {1'b0, acc_r} + {1'b0, alu_b};
    dif9  = {1'b0, acc_r} - {1'b0, alu_b};
    unique case (cw.alu)
      ALU_ADD: begin
        alu_res = sum9[7:0];
        alu_c   = sum9[8];
      end
      ALU_SUB: begin
        alu_res = dif9[7:0];
        alu_c   = !dif9[8];
      end
      default: begin
        alu_res = acc_r;
        alu_c   = c_r;
      end
    endcase
  end

  // Register updates driven by the control word
  always_comb begin
    acc_nxt  = acc_r;
    oreg_nxt = oreg_r;
    pc_nxt   = pc_r;
    c_nxt    = c_r;
    z_nxt    = z_r;
    halt_nxt = halt_r;

    unique case (cw.acc)
      ACC_ALU: acc_nxt = alu_res;
      ACC_MEM: acc_nxt = rdata_r;
      ACC_NIB: acc_nxt = {4'b0000, ir_r[3:0]};
      default: ;
    endcase

    if (cw.flags_ld) begin
      c_nxt = alu_c;
      z_nxt = (alu_res == 8'h00);
    end

    if (cw.oreg_ld) begin
      oreg_nxt = acc_r;
    end

    unique case (cw.pc)
      PC_INC:  pc_nxt = pc_r + 4'd1;
      PC_JMP:  pc_nxt = ir_r[3:0];
      PC_JC:   pc_nxt = c_r ? ir_r[3:0] : pc_r;
      PC_JZ:   pc_nxt = z_r ? ir_r[3:0] : pc_r;
      PC_BACK: pc_nxt = pc_r - 4'd1;  // park on the halt address
      default: ;
    endcase

    if (cw.halt_set) begin
      halt_nxt = 1'b1;
    end

    // restart: clear registers and flags, memory is kept
    if (cw.clr) begin
      acc_nxt  = '0;
      oreg_nxt = '0;
      pc_nxt   = '0;
      c_nxt    = 1'b0;
      z_nxt    = 1'b0;
      halt_nxt = 1'b0;
    end

    // result slot: fill on report, drain on a completed output transaction
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= U_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      oreg_r      <= '0;
      pc_r        <= '0;
      c_r         <= 1'b0;
      z_r         <= 1'b0;
      halt_r      <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      oreg_r      <= oreg_nxt;
      pc_r        <= pc_nxt;
      c_r         <= c_nxt;
      z_r         <= z_nxt;
      halt_r      <= halt_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_addr_r <= in_tdata[5:2];
      item_data_r <= in_tdata[13:6];
    end
    if (cw.ir_ld) begin
      ir_r <= rdata_r;
    end
    if (out_ld) begin
      out_data_r <= {1'b0, halt_r, z_r, c_r, pc_r, oreg_r, acc_r};
    end
  end

endmodule

/* sv/sap1_checker.sv */
// Port-level checker for sap1_instruction_step and the bind that attaches it.
// Depends on sap1_pkg for port widths and the restart op code.
module sap1_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [sap1_pkg::IN_W-1:0]  in_tdata,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [sap1_pkg::OUT_W-1:0] out_tdata
);
  import sap1_pkg::*;

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: the sequencer is busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // a restart with a free output slot reports all-zero state
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] == OP_RESTART) && !out_tvalid
    |-> ##3 (out_tvalid && (out_tdata == '0)))
    else $error("restart did not clear the reported state");

endmodule

bind sap1_instruction_step sap1_checker u_sap1_checker (.*);

/* bench/sap1_instruction_step_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for sap1_instruction_step: directed program table, then random traffic.
// Depends on sap1_pkg (widths, item and opcode codes) and the sap1_instruction_step RTL.
module sap1_instruction_step_test;
  import sap1_pkg::*;

  // Item op with no meaning; the block must only report its state.
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned DEMO_ROWS    = 29;

  // Idle plan per random phase: none, sender idle, receiver stalls, both lightly.
  localparam int unsigned TX_IDLE[4]  = '{0, 81, 0, 8};
  localparam int unsigned RX_STALL[4] = '{0, 0, 81, 8};

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] outv;
    logic [3:0] pc;
    logic       carry;
    logic       zero;
    logic       halted;
  } cpu_status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  addr;
    logic [7:0]  data;
    logic        typed;  // want holds a hand-written expectation
    cpu_status_t want;
  } step_row_t;

  localparam cpu_status_t CLEAR_ST = '0;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  // Predicted CPU state; cpu_written tracks which memory bytes hold defined data.
  logic [7:0]  cpu_mem [16] = '{default: 8'd0};
  logic [15:0] cpu_written  = '0;
  logic [7:0]  cpu_acc      = '0;
  logic [7:0]  cpu_out      = '0;
  logic [3:0]  cpu_pc       = '0;
  logic        cpu_carry    = 1'b0;
  logic        cpu_zero     = 1'b0;
  logic        cpu_halt     = 1'b0;

  cpu_status_t pending_status [$];
  step_row_t   demo_rows [DEMO_ROWS];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  logic        squeeze_req    = 1'b0;
  logic        hold_off       = 1'b0;

  sap1_instruction_step dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] code_byte(input logic [3:0] opc, input logic [3:0] n);
    return {opc, n};
  endfunction

  // Add and subtract update the flags; subtract carry means no borrow.
  function automatic logic [7:0] add_flags(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    cpu_carry = sum[8];
    cpu_zero = (sum[7:0] == 8'd0);
    return sum[7:0];
  endfunction

  function automatic logic [7:0] sub_flags(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] diff;
    diff = a - b;
    cpu_carry = (a >= b);
    cpu_zero = (diff == 8'd0);
    return diff;
  endfunction

  // Apply one accepted transaction to the predicted CPU and return the status it reports.
  function automatic cpu_status_t cpu_step(input logic [1:0] op, input logic [3:0] addr,
                                           input logic [7:0] data);
    logic [7:0] word;
    logic [7:0] operand;
    logic [3:0] opc;
    logic [3:0] n;
    logic [3:0] here;
    cpu_status_t st;
    case (op)
      OP_WRITE: begin
        cpu_mem[addr] = data;
        cpu_written[addr] = 1'b1;
      end
      OP_EXEC: begin
        if (!cpu_halt) begin
          here = cpu_pc;
          word = cpu_mem[here];
          opc = word[7:4];
          n = word[3:0];
          operand = cpu_mem[n];
          cpu_pc = here + 4'd1;
          case (opc)
            OPC_LDA: cpu_acc = operand;
            OPC_ADD: cpu_acc = add_flags(cpu_acc, operand);
            OPC_SUB: cpu_acc = sub_flags(cpu_acc, operand);
            OPC_STA: begin
              cpu_mem[n] = cpu_acc;
              cpu_written[n] = 1'b1;
            end
            OPC_LDI: cpu_acc = {4'd0, n};
            OPC_JMP: cpu_pc = n;
            OPC_JC:  if (cpu_carry) cpu_pc = n;
            OPC_JZ:  if (cpu_zero) cpu_pc = n;
            OPC_INC: cpu_acc = add_flags(cpu_acc, {4'd0, n});
            OPC_DEC: cpu_acc = sub_flags(cpu_acc, {4'd0, n});
            OPC_CMP: operand = sub_flags(cpu_acc, operand);  // flags only
            OPC_OUT: cpu_out = cpu_acc;
            OPC_HLT: begin
              cpu_pc = here;
              cpu_halt = 1'b1;
            end
            default: ;  // NOP and the two spare opcodes
          endcase
        end
      end
      OP_RESTART: begin
        // memory survives a restart
        cpu_acc = '0;
        cpu_out = '0;
        cpu_pc = '0;
        cpu_carry = 1'b0;
        cpu_zero = 1'b0;
        cpu_halt = 1'b0;
      end
      default: ;
    endcase
    st.acc = cpu_acc;
    st.outv = cpu_out;
    st.pc = cpu_pc;
    st.carry = cpu_carry;
    st.zero = cpu_zero;
    st.halted = cpu_halt;
    return st;
  endfunction

  // Offer one transaction, optionally after an idle gap, and queue its expected status
  // once accepted. Valid stays high between back-to-back items.
  task automatic offer_step(input step_row_t row);
    cpu_status_t predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, row.data, row.addr, row.op};
    do @(posedge clk); while (!in_tready);
    predicted = cpu_step(row.op, row.addr, row.data);
    pending_status.push_back(row.typed ? row.want : predicted);
  endtask

  task automatic check_field(input string label, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    out_tready <= !hold_off && ($urandom_range(99) >= rx_stall_pct);
  end

  // Hold the result channel off long enough for the block to fill and stall its input.
  initial begin
    wait (squeeze_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Compare each result transaction with the oldest expectation, field by field.
  always @(posedge clk) begin
    cpu_status_t want;
    if (out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no expectation waiting: expected none, actual %h",
                 $time, out_tdata);
      end else begin
        want = pending_status.pop_front();
        check_field("accumulator", want.acc, out_tdata[7:0]);
        check_field("output_value", want.outv, out_tdata[15:8]);
        check_field("program_counter", {4'd0, want.pc}, {4'd0, out_tdata[19:16]});
        check_field("carry", {7'd0, want.carry}, {7'd0, out_tdata[20]});
        check_field("zero", {7'd0, want.zero}, {7'd0, out_tdata[21]});
        check_field("halted", {7'd0, want.halted}, {7'd0, out_tdata[22]});
      end
    end
  end

  // Watchdog: any run that outlives the limit is a failure.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    step_row_t row;
    logic [7:0] word;
    logic [3:0] opc;
    int unsigned pick;

    // Program: load, add with carry out, taken JC, LDI, DEC to zero, taken JZ,
    // subtract with borrow, INC, CMP, OUT, STA, then halt. Writes before any
    // execute must report the cleared state.
    demo_rows = '{
      '{OP_WRITE, 4'd15, code_byte(OPC_HLT, 4'd15), 1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd0,  code_byte(OPC_LDA, 4'd15), 1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd1,  code_byte(OPC_ADD, 4'd1),  1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd2,  code_byte(OPC_JC,  4'd4),  1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd4,  code_byte(OPC_LDI, 4'd15), 1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd5,  code_byte(OPC_DEC, 4'd15), 1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd6,  code_byte(OPC_JZ,  4'd8),  1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd8,  code_byte(OPC_SUB, 4'd15), 1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd9,  code_byte(OPC_INC, 4'd15), 1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd10, code_byte(OPC_CMP, 4'd1),  1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd11, code_byte(OPC_OUT, 4'd0),  1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd12, code_byte(OPC_STA, 4'd3),  1'b1, CLEAR_ST},
      '{OP_WRITE, 4'd13, code_byte(OPC_HLT, 4'd0),  1'b1, CLEAR_ST},
      '{OP_EXEC,  4'd0,  8'd0,   1'b0, CLEAR_ST},
      '{OP_EXEC,  4'd15, 8'hff,  1'b0, CLEAR_ST},
      '{OP_EXEC,  4'd0,  8'd0,   1'b0, CLEAR_ST},
      '{OP_EXEC,  4'd15, 8'hff,  1'b0, CLEAR_ST},
      '{OP_EXEC,  4'd0,  8'd0,   1'b0, CLEAR_ST},
      '{OP_EXEC,  4'd15, 8'hff,  1'b0, CLEAR_ST},
      '{OP_EXEC,  4'd0,  8'd0,   1'b0, CLEAR_ST},
      '{OP_EXEC,  4'd15, 8'hff,  1'b0, CLEAR_ST},
      '{OP_EXEC,  4'd0,  8'd0,   1'b0, CLEAR_ST},
      '{OP_EXEC,  4'd15, 8'hff,  1'b0, CLEAR_ST},
      '{OP_EXEC,  4'd0,  8'd0,   1'b0, CLEAR_ST},
      '{OP_EXEC,  4'd15, 8'hff,  1'b0, CLEAR_ST},
      // halted: execute changes nothing, a write lands, an unknown op is ignored
      '{OP_EXEC,  4'd0,  8'd0,   1'b0, CLEAR_ST},
      '{OP_WRITE, 4'd14, code_byte(OPC_JMP, 4'd0), 1'b0, CLEAR_ST},
      '{OP_NONE,  4'd15, 8'hff,  1'b0, CLEAR_ST},
      '{OP_RESTART, 4'd15, 8'hff, 1'b1, CLEAR_ST}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (demo_rows[i]) offer_step(demo_rows[i]);

    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_pct = TX_IDLE[phase];
      rx_stall_pct = RX_STALL[phase];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 0 && k == 30)
          squeeze_req = 1'b1;
        row.addr = 4'($urandom_range(15));
        row.data = 8'($urandom_range(255));
        row.typed = 1'b0;
        row.want = CLEAR_ST;
        pick = $urandom_range(99);
        // Mostly run the program; a halted CPU is usually restarted soon.
        if (cpu_halt)
          row.op = (pick < 25) ? OP_RESTART : (pick < 35) ? OP_NONE :
                   (pick < 55) ? OP_WRITE : OP_EXEC;
        else
          row.op = (pick < 3) ? OP_RESTART : (pick < 6) ? OP_NONE :
                   (pick < 30) ? OP_WRITE : OP_EXEC;
        // Never fetch or read a byte that was never written: fill it in instead.
        if (row.op == OP_EXEC && !cpu_halt) begin
          word = cpu_mem[cpu_pc];
          opc = word[7:4];
          if (!cpu_written[cpu_pc]) begin
            row.op = OP_WRITE;
            row.addr = cpu_pc;
          end else if ((opc == OPC_LDA || opc == OPC_ADD || opc == OPC_SUB ||
                        opc == OPC_CMP) && !cpu_written[word[3:0]]) begin
            row.op = OP_WRITE;
            row.addr = word[3:0];
          end
        end
        offer_step(row);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
